// ===== design/iqfsm_pkg.sv =====
// Shared types, constants and the quarter-wave sine generator for the
// frequency shift mixer. No dependencies.
`default_nettype none

package iqfsm_pkg;

  localparam int PHASE_BITS_DEF        = 32;
  localparam int SINE_ADDRESS_BITS_DEF = 10;

  localparam int SAMPLE_W   = 8;
  localparam int STEP_W     = 29;
  localparam int MIXED_W    = 16;
  localparam int ENERGY_W   = 48;
  localparam int COUNT_W    = 32;
  localparam int SINE_W     = 16;
  localparam int SINE_MAG_W = 15;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = STEP_W'(150324);

  // Depth of the queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;

  // pi/2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  // Quarter-wave sine entry k of 2^qbits, in Q14. Only evaluated at
  // elaboration to build the constant table.
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned k,
                                                         input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p3;
    logic [63:0] p5;
    logic [63:0] p7;
    logic [63:0] p9;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] r;
    x   = (64'(k) * HALF_PI_Q30) >> qbits;
    x2  = (x * x) >> 30;
    p3  = (x * x2) >> 30;
    p5  = (p3 * x2) >> 30;
    p7  = (p5 * x2) >> 30;
    p9  = (p7 * x2) >> 30;
    pos = x + p5 / 64'd120 + p9 / 64'd362880;
    neg = p3 / 64'd6 + p7 / 64'd5040;
    s   = (pos > neg) ? pos - neg : 64'd0;
    r   = (s + 64'd32768) >> 16;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[SINE_MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/iqfsm_fifo.sv =====
// Short register queue between the front and back parts of the mixer.
// Depends on iqfsm_pkg.
`default_nettype none

module iqfsm_fifo #(
  parameter int WIDTH = 27
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [WIDTH-1:0]   push_data,
  input  wire logic               pop,
  output iqfsm_pkg::fifo_stat_t   stat,
  output logic      [WIDTH-1:0]   head_data
);
  import iqfsm_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign stat.full      = (count_r == CNT_W'(FIFO_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign head_data      = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/iqfsm_front.sv =====
// Front part of the mixer: takes input transactions, holds the phase step
// register and the phase accumulator, and queues each sample with its
// sine table address. Depends on iqfsm_pkg.
`default_nettype none

module iqfsm_front #(
  parameter int PHASE_BITS        = iqfsm_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDRESS_BITS = iqfsm_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  input  wire logic [2*iqfsm_pkg::SAMPLE_W-1:0]           in_tdata,
  input  wire logic                                       in_tuser,
  input  wire logic                                       cfg_wr_en,
  input  wire logic [iqfsm_pkg::STEP_W-1:0]               cfg_wr_data,
  input  wire iqfsm_pkg::fifo_stat_t                      fifo_stat,
  output logic                                            fifo_push,
  output logic [SINE_ADDRESS_BITS+2*iqfsm_pkg::SAMPLE_W:0] fifo_data
);
  import iqfsm_pkg::*;

  localparam int EXT_W = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

  logic [STEP_W-1:0]     phase_step_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [EXT_W-1:0]      step_ext;

  assign in_tready = !fifo_stat.full;
  assign fifo_push = in_tvalid && in_tready;
  // Entry layout, lowest bits first: sample_i, sample_q, restart, address.
  assign fifo_data = {phase_r[PHASE_BITS-1 -: SINE_ADDRESS_BITS], in_tuser, in_tdata};
  assign step_ext  = EXT_W'(signed'(phase_step_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RESET;
      phase_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        phase_step_r <= cfg_wr_data;
      end
      if (fifo_push) begin
        phase_r <= phase_r + step_ext[PHASE_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/iqfsm_back.sv =====
// Back part of the mixer: sine and cosine lookup, complex multiply,
// rounding and saturation, energy accumulation and the output register.
// Depends on iqfsm_pkg.
`default_nettype none

module iqfsm_back #(
  parameter int SINE_ADDRESS_BITS = iqfsm_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire iqfsm_pkg::fifo_stat_t                       fifo_stat,
  input  wire logic [SINE_ADDRESS_BITS+2*iqfsm_pkg::SAMPLE_W:0] fifo_data,
  output logic                                             fifo_pop,
  output logic                                             out_tvalid,
  input  wire logic                                        out_tready,
  output logic [2*iqfsm_pkg::MIXED_W+iqfsm_pkg::ENERGY_W+iqfsm_pkg::COUNT_W-1:0] out_tdata
);
  import iqfsm_pkg::*;

  localparam int QBITS = SINE_ADDRESS_BITS - 2;
  localparam int QSIZE = 1 << QBITS;
  localparam int PROD_W = SAMPLE_W + SINE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int E_W    = 2 * SAMPLE_W + 1;

  // Quarter-wave table, entries 0 through QSIZE inclusive.
  logic [SINE_MAG_W-1:0] qtab [QSIZE+1];
  for (genvar g = 0; g <= QSIZE; g++) begin : g_qtab
    localparam logic [SINE_MAG_W-1:0] ENTRY = quarter_sine(g, QBITS);
    assign qtab[g] = ENTRY;
  end

  function automatic logic [MIXED_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + SUM_W'(64)) >>> 7;
    if (r > SUM_W'(32767)) begin
      return 16'h7fff;
    end else if (r < -SUM_W'(32768)) begin
      return 16'h8000;
    end
    return r[MIXED_W-1:0];
  endfunction

  logic adv;

  // Head of the queue.
  logic signed [SAMPLE_W-1:0]        h_i;
  logic signed [SAMPLE_W-1:0]        h_q;
  logic                              h_restart;
  logic [SINE_ADDRESS_BITS-1:0]      h_addr;
  logic [1:0]                        quad_s;
  logic [1:0]                        quad_c;
  logic [QBITS-1:0]                  k;
  logic [QBITS:0]                    idx_s;
  logic [QBITS:0]                    idx_c;
  logic signed [SINE_W-1:0]          mag_s;
  logic signed [SINE_W-1:0]          mag_c;
  logic signed [SINE_W-1:0]          sin_nxt;
  logic signed [SINE_W-1:0]          cos_nxt;

  // Lookup stage.
  logic                              s1_valid_r;
  logic signed [SAMPLE_W-1:0]        s1_i_r;
  logic signed [SAMPLE_W-1:0]        s1_q_r;
  logic                              s1_restart_r;
  logic signed [SINE_W-1:0]          s1_sin_r;
  logic signed [SINE_W-1:0]          s1_cos_r;

  // Product stage.
  logic                              s2_valid_r;
  logic signed [PROD_W-1:0]          p_ic_r;
  logic signed [PROD_W-1:0]          p_qs_r;
  logic signed [PROD_W-1:0]          p_is_r;
  logic signed [PROD_W-1:0]          p_qc_r;
  logic [E_W-1:0]                    s2_energy_r;
  logic                              s2_restart_r;
  logic signed [2*SAMPLE_W-1:0]      sq_i;
  logic signed [2*SAMPLE_W-1:0]      sq_q;

  // Output stage and accumulators.
  logic                              out_valid_r;
  logic [MIXED_W-1:0]                out_i_r;
  logic [MIXED_W-1:0]                out_q_r;
  logic [ENERGY_W-1:0]               total_r;
  logic [ENERGY_W-1:0]               total_nxt;
  logic [COUNT_W-1:0]                tally_r;
  logic [COUNT_W-1:0]                tally_nxt;
  logic [ENERGY_W-1:0]               total_base;
  logic [COUNT_W-1:0]                tally_base;
  logic [ENERGY_W:0]                 total_sum;
  logic signed [SUM_W-1:0]           re_sum;
  logic signed [SUM_W-1:0]           im_sum;

  // The whole pipeline moves together whenever the output slot frees up.
  assign adv      = !out_valid_r || out_tready;
  assign fifo_pop = adv && fifo_stat.not_empty;

  assign h_i       = fifo_data[SAMPLE_W-1:0];
  assign h_q       = fifo_data[2*SAMPLE_W-1:SAMPLE_W];
  assign h_restart = fifo_data[2*SAMPLE_W];
  assign h_addr    = fifo_data[2*SAMPLE_W+1 +: SINE_ADDRESS_BITS];

  // Cosine is the sine a quarter turn ahead: same offset, next quadrant.
  always_comb begin
    quad_s  = h_addr[SINE_ADDRESS_BITS-1 -: 2];
    quad_c  = quad_s + 2'd1;
    k       = h_addr[QBITS-1:0];
    idx_s   = quad_s[0] ? ((QBITS+1)'(QSIZE) - {1'b0, k}) : {1'b0, k};
    idx_c   = quad_c[0] ? ((QBITS+1)'(QSIZE) - {1'b0, k}) : {1'b0, k};
    mag_s   = signed'({1'b0, qtab[idx_s]});
    mag_c   = signed'({1'b0, qtab[idx_c]});
    sin_nxt = quad_s[1] ? -mag_s : mag_s;
    cos_nxt = quad_c[1] ? -mag_c : mag_c;
  end

  assign sq_i = (2*SAMPLE_W)'(s1_i_r) * (2*SAMPLE_W)'(s1_i_r);
  assign sq_q = (2*SAMPLE_W)'(s1_q_r) * (2*SAMPLE_W)'(s1_q_r);

  always_comb begin
    re_sum     = SUM_W'(p_ic_r) - SUM_W'(p_qs_r);
    im_sum     = SUM_W'(p_is_r) + SUM_W'(p_qc_r);
    total_base = s2_restart_r ? '0 : total_r;
    tally_base = s2_restart_r ? '0 : tally_r;
    total_sum  = {1'b0, total_base} + (ENERGY_W+1)'(s2_energy_r);
    total_nxt  = total_sum[ENERGY_W] ? '1 : total_sum[ENERGY_W-1:0];
    tally_nxt  = (tally_base == '1) ? tally_base : tally_base + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      tally_r     <= '0;
    end else if (adv) begin
      s1_valid_r  <= fifo_stat.not_empty;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        total_r <= total_nxt;
        tally_r <= tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_i_r       <= h_i;
      s1_q_r       <= h_q;
      s1_restart_r <= h_restart;
      s1_sin_r     <= sin_nxt;
      s1_cos_r     <= cos_nxt;
      p_ic_r       <= PROD_W'(s1_i_r) * PROD_W'(s1_cos_r);
      p_qs_r       <= PROD_W'(s1_q_r) * PROD_W'(s1_sin_r);
      p_is_r       <= PROD_W'(s1_i_r) * PROD_W'(s1_sin_r);
      p_qc_r       <= PROD_W'(s1_q_r) * PROD_W'(s1_cos_r);
      s2_energy_r  <= {1'b0, unsigned'(sq_i)} + {1'b0, unsigned'(sq_q)};
      s2_restart_r <= s1_restart_r;
      out_i_r      <= round_sat(re_sum);
      out_q_r      <= round_sat(im_sum);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {tally_r, total_r, out_q_r, out_i_r};

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid not cleared by reset");

  a_restart_count_one: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_restart_r) |=> (tally_r == COUNT_W'(1)))
    else $error("sample count not restarted at one");

  a_energy_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && !s2_restart_r) |=> (total_r >= $past(total_r)))
    else $error("energy sum decreased without restart");

  a_valid_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (tally_r != '0))
    else $error("result presented with zero sample count");

endmodule

`default_nettype wire

// ===== design/iq_frequency_shift_mixer_top.sv =====
// Top level of the I/Q frequency shift mixer with power accumulator.
// Depends on iqfsm_pkg, iqfsm_front, iqfsm_fifo and iqfsm_back.
// A result appears on out_tvalid once its transaction has passed the queue and the
// lookup, product and output registers. Throughput: one transaction per clock unless
// out_tready stalls, set by the phase accumulator and the three-stage pipeline.
// Reset (synchronous, rst_n low): phase, energy sum, count and queue clear;
// phase_step returns to 150324.
`default_nettype none

module iq_frequency_shift_mixer_top #(
  parameter int PHASE_BITS        = iqfsm_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDRESS_BITS = iqfsm_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input samples.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // sample_i [7:0], sample_q [15:8]
  input  wire logic         in_tuser,   // restart_energy
  // Results.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // mixed_i [15:0], mixed_q [31:16],
                                        // energy_sum [79:32], energy_count [111:80]
  // Phase step register, signed, in units of one turn over 2^PHASE_BITS.
  input  wire logic         cfg_wr_en,
  input  wire logic [28:0]  cfg_wr_data
);
  import iqfsm_pkg::*;

  localparam int ENTRY_W = SINE_ADDRESS_BITS + 2 * SAMPLE_W + 1;

  // The front part owns the phase accumulator, so the oscillator phase of a
  // sample is fixed the moment its transaction is accepted. The back part
  // only sees queued entries and can stall on out_tready without ever
  // disturbing the phase sequence.
  fifo_stat_t         fifo_stat;
  logic               fifo_push;
  logic               fifo_pop;
  logic [ENTRY_W-1:0] fifo_wdata;
  logic [ENTRY_W-1:0] fifo_rdata;

  iqfsm_front #(
    .PHASE_BITS        (PHASE_BITS),
    .SINE_ADDRESS_BITS (SINE_ADDRESS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fifo_stat   (fifo_stat),
    .fifo_push   (fifo_push),
    .fifo_data   (fifo_wdata)
  );

  // A short queue decouples acceptance from the arithmetic pipeline; while
  // out_tready is low the front keeps accepting until it fills.
  iqfsm_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .pop       (fifo_pop),
    .stat      (fifo_stat),
    .head_data (fifo_rdata)
  );

  // The back part looks up sine and cosine, multiplies, rounds half up and
  // saturates to Q2.14, and updates the saturating energy sum and count.
  iqfsm_back #(
    .SINE_ADDRESS_BITS (SINE_ADDRESS_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .fifo_data  (fifo_rdata),
    .fifo_pop   (fifo_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/iq_frequency_shift_mixer_top_tb.sv =====
// Self-checking testbench for the I/Q frequency shift mixer top level.
// Depends on iqfsm_pkg and iq_frequency_shift_mixer_top; it predicts every
// rotated sample and energy total and compares them with the result stream.
`timescale 1ns / 100ps

module iq_frequency_shift_mixer_top_tb;
  import iqfsm_pkg::*;

  // Oscillator geometry, taken from the default build of the block.
  localparam int ADDR_W      = SINE_ADDRESS_BITS_DEF;
  localparam int QTR_BITS    = ADDR_W - 2;
  localparam int QTR_SIZE    = 1 << QTR_BITS;
  localparam int PH_W        = PHASE_BITS_DEF;
  localparam logic [ENERGY_W-1:0] ENERGY_CEIL = '1;
  localparam logic [COUNT_W-1:0]  COUNT_CEIL  = '1;
  // Limits of the offset range that the application uses.
  localparam int STEP_APP_MAX = 214748365;
  localparam int MAX_REPORTS  = 40;

  // One result, laid out exactly as out_tdata packs it (mixed_i lowest).
  typedef struct packed {
    logic [COUNT_W-1:0]         ecount;
    logic [ENERGY_W-1:0]        esum;
    logic signed [MIXED_W-1:0]  mq;
    logic signed [MIXED_W-1:0]  mi;
  } mixer_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;   // sample_i [7:0], sample_q [15:8]
  logic         in_tuser;   // restart_energy
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;  // mixed_i [15:0], mixed_q [31:16],
                            // energy_sum [79:32], energy_count [111:80]
  logic         cfg_wr_en;
  logic [28:0]  cfg_wr_data;

  // Predictor state: the oscillator phase, the energy totals and the step.
  logic [PH_W-1:0]      osc_phase;
  logic [ENERGY_W-1:0]  energy_total;
  logic [COUNT_W-1:0]   sample_tally;
  logic [STEP_W-1:0]    step_model;
  logic [SINE_MAG_W-1:0] quarter_wave [0:QTR_SIZE];

  // Results predicted for accepted samples, oldest first.
  mixer_result_t pending_mixes[$];
  int            mismatch_count;

  // Traffic shaping. steady_traffic turns off random idling on both sides;
  // hold_request asks the receiver to stall for that many cycles.
  bit steady_traffic;
  int hold_request;

  iq_frequency_shift_mixer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Quarter-wave entry k in Q14: a Taylor series of sin evaluated in Q30,
  // odd powers built one after another, each term truncated on division.
  function automatic logic [SINE_MAG_W-1:0] quarter_entry(int unsigned k);
    longint unsigned term_div [0:4] = '{1, 6, 120, 5040, 362880};
    longint unsigned angle;
    longint unsigned ang_sq;
    longint unsigned power;
    longint unsigned plus_sum;
    longint unsigned minus_sum;
    longint unsigned net;
    longint unsigned rounded;
    angle     = (longint'(k) * HALF_PI_Q30) >> QTR_BITS;
    ang_sq    = (angle * angle) >> 30;
    power     = angle;
    plus_sum  = 0;
    minus_sum = 0;
    for (int n = 0; n < 5; n++) begin
      if (n > 0) begin
        power = (power * ang_sq) >> 30;
      end
      if (n % 2 == 0) begin
        plus_sum += power / term_div[n];
      end else begin
        minus_sum += power / term_div[n];
      end
    end
    net     = (plus_sum > minus_sum) ? plus_sum - minus_sum : 0;
    rounded = (net + 32768) >> 16;
    if (rounded > 16384) begin
      rounded = 16384;
    end
    return rounded[SINE_MAG_W-1:0];
  endfunction

  // Full-turn sine from the quarter table: odd quadrants run the quarter
  // backwards, the lower half-turn is negated.
  function automatic int oscillator_value(logic [ADDR_W-1:0] addr);
    logic [QTR_BITS-1:0] k;
    int mag;
    k   = addr[QTR_BITS-1:0];
    mag = addr[QTR_BITS] ? int'(quarter_wave[QTR_SIZE - int'(k)]) : int'(quarter_wave[k]);
    return addr[ADDR_W-1] ? -mag : mag;
  endfunction

  // Divide by 128 rounding half up, then clamp to the 16-bit range.
  function automatic logic [MIXED_W-1:0] round_q14(int acc);
    int r;
    r = (acc + 64) >>> 7;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[MIXED_W-1:0];
  endfunction

  // Rotates one sample, updates the energy totals and advances the phase.
  function automatic mixer_result_t advance_mixer_model(logic [SAMPLE_W-1:0] si,
                                                        logic [SAMPLE_W-1:0] sq,
                                                        logic restart);
    int i_val;
    int q_val;
    int s_val;
    int c_val;
    int sq_energy;
    logic [ADDR_W-1:0] addr;
    mixer_result_t res;
    i_val = $signed(si);
    q_val = $signed(sq);
    addr  = osc_phase[PH_W-1 -: ADDR_W];
    s_val = oscillator_value(addr);
    c_val = oscillator_value(addr + ADDR_W'(QTR_SIZE));
    res.mi = round_q14(i_val * c_val - q_val * s_val);
    res.mq = round_q14(i_val * s_val + q_val * c_val);
    if (restart) begin
      energy_total = '0;
      sample_tally = '0;
    end
    sq_energy = i_val * i_val + q_val * q_val;
    if (ENERGY_CEIL - energy_total < ENERGY_W'(sq_energy)) begin
      energy_total = ENERGY_CEIL;
    end else begin
      energy_total = energy_total + ENERGY_W'(sq_energy);
    end
    if (sample_tally != COUNT_CEIL) begin
      sample_tally = sample_tally + 1'b1;
    end
    res.esum   = energy_total;
    res.ecount = sample_tally;
    osc_phase  = osc_phase + PH_W'($signed(step_model));
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // Offers one sample transaction and predicts its result when it is taken.
  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so back-to-back calls stream without gaps.
  task automatic send_sample(logic [SAMPLE_W-1:0] si, logic [SAMPLE_W-1:0] sq,
                             logic restart);
    while (!steady_traffic && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sq, si};
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pending_mixes.push_back(advance_mixer_model(si, sq, restart));
    @(negedge clk);
  endtask

  // Random sample content: mostly uniform, sometimes a corner value, with
  // an occasional energy restart.
  task automatic send_random_sample();
    logic [SAMPLE_W-1:0] si;
    logic [SAMPLE_W-1:0] sq;
    logic restart;
    si = SAMPLE_W'($urandom);
    sq = SAMPLE_W'($urandom);
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 4))
        0: si = 8'h80;
        1: si = 8'h7F;
        2: si = 8'hFF;
        3: si = 8'h01;
        default: si = 8'h00;
      endcase
    end
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 4))
        0: sq = 8'h80;
        1: sq = 8'h7F;
        2: sq = 8'hFF;
        3: sq = 8'h01;
        default: sq = 8'h00;
      endcase
    end
    restart = ($urandom_range(0, 24) == 0);
    send_sample(si, sq, restart);
  endtask

  // Stops offering samples and waits until every predicted result has come
  // back, and then waits on for anything still in the pipeline.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_mixes.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(negedge clk);
  endtask

  // Writes the phase step while the block is idle.
  task automatic program_phase_step(logic [STEP_W-1:0] step);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= step;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    step_model  = step;
  endtask

  // Only called while drained; the flag changes at a rising edge so the
  // processes that read it at falling edges never race with the write.
  task automatic set_steady(bit on);
    @(posedge clk);
    steady_traffic = on;
    @(negedge clk);
  endtask

  // A random step: mostly inside the application range, sometimes any
  // 29-bit value.
  function automatic logic [STEP_W-1:0] random_step();
    if ($urandom_range(0, 3) == 0) begin
      return STEP_W'($urandom);
    end
    return STEP_W'(int'($urandom_range(0, 2 * STEP_APP_MAX)) - STEP_APP_MAX);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner values of both sample fields at the reset step, with an energy
  // restart near the end of the run.
  task automatic test_field_extremes();
    send_sample(8'h00, 8'h00, 1'b0);
    send_sample(8'h7F, 8'h00, 1'b0);
    send_sample(8'h80, 8'h00, 1'b0);
    send_sample(8'h00, 8'h7F, 1'b0);
    send_sample(8'h00, 8'h80, 1'b0);
    send_sample(8'h7F, 8'h7F, 1'b0);
    send_sample(8'h80, 8'h80, 1'b0);
    send_sample(8'h7F, 8'h80, 1'b0);
    send_sample(8'h80, 8'h7F, 1'b1);
    send_sample(8'hFF, 8'hFF, 1'b0);
  endtask

  // The most negative step is exactly one sixteenth of a turn, so a full
  // turn lands on every quadrant edge, including the table's end entry.
  task automatic test_quadrant_boundaries();
    program_phase_step(STEP_W'(-(1 << 28)));
    for (int n = 0; n < 16; n++) begin
      send_sample(n[0] ? 8'h7F : 8'h80, n[1] ? 8'h80 : 8'h7F, n == 15);
    end
  endtask

  // Largest positive step, both ends of the application range, zero and
  // the smallest steps either way, each with a short random burst.
  task automatic test_step_extremes();
    logic [STEP_W-1:0] steps [0:5];
    steps[0] = STEP_W'((1 << 28) - 1);
    steps[1] = STEP_W'(STEP_APP_MAX);
    steps[2] = STEP_W'(-STEP_APP_MAX);
    steps[3] = '0;
    steps[4] = STEP_W'(1);
    steps[5] = '1;
    foreach (steps[s]) begin
      program_phase_step(steps[s]);
      repeat (40) send_random_sample();
    end
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering
  // transactions, so the internal queue fills and in_tready drops.
  task automatic test_output_backpressure();
    drain_results();
    set_steady(1'b1);
    @(posedge clk);
    hold_request = 400;
    @(negedge clk);
    repeat (60) send_random_sample();
    drain_results();
    set_steady(1'b0);
  endtask

  // Long random traffic over several step settings; one phase runs with no
  // idling on either side.
  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      program_phase_step(random_step());
      if (p == 2) begin
        set_steady(1'b1);
      end
      repeat (330) send_random_sample();
      if (p == 2) begin
        drain_results();
        set_steady(1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver and result checking
  // ---------------------------------------------------------------------

  // Receiver: out_tready changes at falling edges. A pending hold forces a
  // stall for that many cycles; otherwise it stalls about a quarter of the
  // time unless steady traffic is on.
  initial begin : receiver
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= steady_traffic ? 1'b1 : ($urandom_range(0, 99) >= 26);
      end
    end
  end

  task automatic compare_field(string label, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      end
    end
  endtask

  // Every result transaction is compared, field by field, with the oldest
  // prediction. Outputs are sampled at the rising edge, before the block
  // updates them.
  always @(posedge clk) begin
    mixer_result_t got;
    mixer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = mixer_result_t'(out_tdata);
      if (pending_mixes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result transaction expected none actual 0x%h", $time, out_tdata);
        end
      end else begin
        want = pending_mixes.pop_front();
        compare_field("mixed_i", want.mi, got.mi);
        compare_field("mixed_q", want.mq, got.mq);
        compare_field("energy_sum", want.esum, got.esum);
        compare_field("energy_count", want.ecount, got.ecount);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    steady_traffic = 1'b0;
    hold_request   = 0;
    mismatch_count = 0;
    osc_phase      = '0;
    energy_total   = '0;
    sample_tally   = '0;
    step_model     = PHASE_STEP_RESET;
    for (int k = 0; k <= QTR_SIZE; k++) begin
      quarter_wave[k] = quarter_entry(k);
    end

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_quadrant_boundaries();
    test_step_extremes();
    test_output_backpressure();
    test_random_traffic();

    // Wait for the last results and make sure nothing extra follows.
    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/iqfsm_pkg.sv
design/iqfsm_fifo.sv
design/iqfsm_front.sv
design/iqfsm_back.sv
design/iq_frequency_shift_mixer_top.sv
tb/iq_frequency_shift_mixer_top_tb.sv
